// ----- design/adjacency_matrix_degree_query_defines.svh -----
// assertion helpers for the adjacency matrix block
`ifndef ADJACENCY_MATRIX_DEGREE_QUERY_DEFINES_SVH
`define ADJACENCY_MATRIX_DEGREE_QUERY_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define AMDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amdq check failed");

// next-cycle implication on clk, off during reset
`define AMDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amdq check failed");

`endif

// ----- design/amdq_pkg.sv -----
package amdq_pkg;

  localparam int ACT_W  = 3;
  localparam int NODE_W = 4;
  localparam int ROW_W  = 16;
  localparam int DEG_W  = 5;
  localparam int NC_W   = 5;

  localparam logic [NC_W-1:0] NC_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE    = 3'd0,
    ACT_DEGREES  = 3'd1,
    ACT_MAX_OUT  = 3'd2,
    ACT_BOTHWAYS = 3'd3,
    ACT_ARRIVALS = 3'd4,
    ACT_CLASSIFY = 3'd5
  } action_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic query;
    logic last;
  } ctl_sts_t;

  function automatic logic [DEG_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [DEG_W-1:0] c;
    c = '0;
    for (int k = 0; k < ROW_W; k++) begin
      c = c + DEG_W'(v[k]);
    end
    return c;
  endfunction

endpackage

// ----- design/amdq_in_if.sv -----
interface amdq_in_if;
  import amdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NODE_W-1:0] node;
  logic [ROW_W-1:0]  row_bits;

  modport source (output valid, action, node, row_bits, input ready);
  modport sink (input valid, action, node, row_bits, output ready);
endinterface

// ----- design/amdq_out_if.sv -----
interface amdq_out_if;
  import amdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [DEG_W-1:0]  out_degree;
  logic [DEG_W-1:0]  in_degree;
  logic [NODE_W-1:0] best_node;
  logic              both_ways;
  logic [ROW_W-1:0]  arrive_mask;
  logic [ROW_W-1:0]  isolated_mask;
  logic [ROW_W-1:0]  only_in_mask;
  logic [ROW_W-1:0]  only_out_mask;

  modport source (output valid, out_degree, in_degree, best_node, both_ways, arrive_mask,
                  isolated_mask, only_in_mask, only_out_mask, input ready);
  modport sink (input valid, out_degree, in_degree, best_node, both_ways, arrive_mask,
                isolated_mask, only_in_mask, only_out_mask, output ready);
endinterface

// ----- design/amdq_ctrl.sv -----
module amdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  amdq_pkg::ctl_sts_t sts,
  output amdq_pkg::ctl_cmd_t cmd
);
  import amdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.query ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/amdq_datapath.sv -----
module amdq_datapath #(
  parameter int MAX_NODES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [amdq_pkg::NC_W-1:0]     cfg_data,
  input  logic [amdq_pkg::ACT_W-1:0]    in_action,
  input  logic [amdq_pkg::NODE_W-1:0]   in_node,
  input  logic [amdq_pkg::ROW_W-1:0]    in_row_bits,
  input  amdq_pkg::ctl_cmd_t            cmd,
  output amdq_pkg::ctl_sts_t            sts,
  output logic [amdq_pkg::DEG_W-1:0]    out_degree,
  output logic [amdq_pkg::DEG_W-1:0]    in_degree,
  output logic [amdq_pkg::NODE_W-1:0]   best_node,
  output logic                          both_ways,
  output logic [amdq_pkg::ROW_W-1:0]    arrive_mask,
  output logic [amdq_pkg::ROW_W-1:0]    isolated_mask,
  output logic [amdq_pkg::ROW_W-1:0]    only_in_mask,
  output logic [amdq_pkg::ROW_W-1:0]    only_out_mask
);
  import amdq_pkg::*;

  localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int AW   = $clog2(ROWS);
  localparam logic [NC_W-1:0] ROWS_N = NC_W'(ROWS);

  logic [ROW_W-1:0]  mem [ROWS];

  logic [NC_W-1:0]   node_count_r;
  action_t           act_r;
  logic [NODE_W-1:0] node_r;
  logic [NODE_W-1:0] idx_r;
  logic [ROW_W-1:0]  rd_data_r;
  logic [NODE_W-1:0] rd_idx_r;
  logic              rd_vld_r;

  logic [DEG_W-1:0]  own_deg_r;
  logic [DEG_W-1:0]  in_acc_r;
  logic [DEG_W-1:0]  best_deg_r;
  logic [NODE_W-1:0] best_r;
  logic              col_ok_r;
  logic              row_ok_r;
  logic [ROW_W-1:0]  arrive_r;
  logic [ROW_W-1:0]  entry_r;
  logic [ROW_W-1:0]  exit_r;

  logic [NC_W-1:0]   n_live;
  logic [ROW_W-1:0]  col_mask;
  logic [ROW_W-1:0]  row_m;
  logic [ROW_W-1:0]  row_other;
  logic [ROW_W-1:0]  node_hot;
  logic [ROW_W-1:0]  idx_hot;
  logic [DEG_W-1:0]  pc;
  logic              bit_in;
  logic              node_ok;
  action_t           in_act;

  // live node count, clamped
  always_comb begin
    n_live = node_count_r;
    if (n_live == '0) begin
      n_live = NC_W'(1);
    end
    if (n_live > NC_W'(ROW_W)) begin
      n_live = NC_W'(ROW_W);
    end
    if (n_live > ROWS_N) begin
      n_live = ROWS_N;
    end
  end

  assign col_mask  = ROW_W'((17'd1 << n_live) - 17'd1);
  assign in_act    = action_t'(in_action);
  assign node_hot  = ROW_W'(1) << node_r;
  assign idx_hot   = ROW_W'(1) << rd_idx_r;
  assign row_m     = rd_data_r & col_mask;
  assign row_other = row_m & ~idx_hot;
  assign pc        = popcount(row_m);
  assign bit_in    = row_m[node_r];
  assign node_ok   = ({1'b0, node_r} < n_live);

  always_comb begin
    sts.last = ({1'b0, idx_r} == (n_live - NC_W'(1)));
    case (in_act) inside
      ACT_DEGREES, ACT_MAX_OUT, ACT_BOTHWAYS, ACT_ARRIVALS, ACT_CLASSIFY: sts.query = 1'b1;
      default: sts.query = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NC_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_data;
    end
  end

  // edge matrix, one row per node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        mem[r] <= '0;
      end
    end else if (cmd.start && in_act == ACT_WRITE && {1'b0, in_node} < ROWS_N) begin
      mem[in_node[AW-1:0]] <= in_row_bits | (ROW_W'(1) << in_node);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
      rd_idx_r  <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      act_r    <= ACT_WRITE;
      node_r   <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.start) begin
        idx_r  <= '0;
        act_r  <= in_act;
        node_r <= in_node;
      end else if (cmd.scan) begin
        idx_r <= idx_r + NODE_W'(1);
      end
    end
  end

  // per-row accumulation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      own_deg_r  <= '0;
      in_acc_r   <= '0;
      best_deg_r <= '0;
      best_r     <= '0;
      col_ok_r   <= 1'b1;
      row_ok_r   <= 1'b0;
      arrive_r   <= '0;
      entry_r    <= '0;
      exit_r     <= '0;
    end else if (rd_vld_r) begin
      in_acc_r           <= in_acc_r + DEG_W'(bit_in);
      arrive_r[rd_idx_r] <= bit_in;
      entry_r            <= entry_r | row_other;
      exit_r[rd_idx_r]   <= |row_other;
      if (rd_idx_r == node_r) begin
        own_deg_r <= pc;
        row_ok_r  <= ((row_m | node_hot) == col_mask);
      end else begin
        col_ok_r <= col_ok_r & bit_in;
      end
      if (rd_idx_r == '0 || pc > best_deg_r) begin
        best_deg_r <= pc;
        best_r     <= rd_idx_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_degree    <= '0;
      in_degree     <= '0;
      best_node     <= '0;
      both_ways     <= 1'b0;
      arrive_mask   <= '0;
      isolated_mask <= '0;
      only_in_mask  <= '0;
      only_out_mask <= '0;
      case (act_r)
        ACT_DEGREES: begin
          if (node_ok) begin
            out_degree <= own_deg_r;
            in_degree  <= in_acc_r;
          end
        end
        ACT_MAX_OUT: begin
          out_degree <= best_deg_r;
          best_node  <= best_r;
        end
        ACT_BOTHWAYS: begin
          both_ways <= node_ok && col_ok_r && row_ok_r;
        end
        ACT_ARRIVALS: begin
          if (node_ok) begin
            arrive_mask <= arrive_r;
          end
        end
        ACT_CLASSIFY: begin
          isolated_mask <= ~entry_r & ~exit_r & col_mask;
          only_in_mask  <= entry_r & ~exit_r;
          only_out_mask <= ~entry_r & exit_r;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/adjacency_matrix_degree_query.sv -----
// Directed adjacency bit matrix of up to 16 nodes with degree and connectivity queries.
// For a row write (action 0) the matrix row is written on accept and the done state then loads the result.
// Every query scans the n live rows of the matrix one per cycle through its single read
// port, then a drain state takes in the last row and the done state loads the result.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken, and that item holds before its own result until the register
// frees. cfg_we loads node_count (reset 16; 0 acts as 1) and may be written only while
// the block is idle.
module adjacency_matrix_degree_query #(
  parameter int MAX_NODES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [amdq_pkg::NC_W-1:0] cfg_data,
  amdq_in_if.sink                   in_ch,
  amdq_out_if.source                out_ch
);
  import amdq_pkg::*;

  `include "adjacency_matrix_degree_query_defines.svh"

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  amdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  amdq_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_action     (in_ch.action),
    .in_node       (in_ch.node),
    .in_row_bits   (in_ch.row_bits),
    .cmd           (cmd),
    .sts           (sts),
    .out_degree    (out_ch.out_degree),
    .in_degree     (out_ch.in_degree),
    .best_node     (out_ch.best_node),
    .both_ways     (out_ch.both_ways),
    .arrive_mask   (out_ch.arrive_mask),
    .isolated_mask (out_ch.isolated_mask),
    .only_in_mask  (out_ch.only_in_mask),
    .only_out_mask (out_ch.only_out_mask)
  );

  // one item in work at a time
  `AMDQ_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready)
  // no result in the cycle right after an accept
  `AMDQ_ASSERT_NEXT(a_no_early_result, in_ch.valid && in_ch.ready, !$rose(out_ch.valid))
  // a new result means the controller is back to taking beats
  `AMDQ_ASSERT_NOW(a_ready_after_result, $rose(out_ch.valid), in_ch.ready)

endmodule

// ----- tb/tb_adjacency_matrix_degree_query.sv -----
module tb_adjacency_matrix_degree_query;
  timeunit 1ns;
  timeprecision 1ps;
  import amdq_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES    = 30;
  localparam int MAX_GAP         = 13;
  localparam int PRINT_LIMIT     = 100;

  // unused action codes, no state change and all-zero answer
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [DEG_W-1:0]  out_degree;
    logic [DEG_W-1:0]  in_degree;
    logic [NODE_W-1:0] best_node;
    logic              both_ways;
    logic [ROW_W-1:0]  arrive_mask;
    logic [ROW_W-1:0]  isolated_mask;
    logic [ROW_W-1:0]  only_in_mask;
    logic [ROW_W-1:0]  only_out_mask;
  } degree_answer_t;

  class adjacency_shadow;
    logic [ROW_W-1:0] rows [16];
    logic [NC_W-1:0]  node_count;
    degree_answer_t   answers_due [$];
    int               errors;
    int               checked;

    function void clear();
      foreach (rows[i]) rows[i] = '0;
      node_count = NC_RESET;
      answers_due.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int live_nodes();
      if (node_count == 0) return 1;
      if (node_count > 16) return 16;
      return int'(node_count);
    endfunction

    function logic [DEG_W-1:0] row_out_degree(int v, int n);
      logic [DEG_W-1:0] c;
      c = '0;
      for (int j = 0; j < n; j++) c += DEG_W'(rows[v][j]);
      return c;
    endfunction

    function logic [DEG_W-1:0] column_in_degree(int v, int n);
      logic [DEG_W-1:0] c;
      c = '0;
      for (int i = 0; i < n; i++) c += DEG_W'(rows[i][v]);
      return c;
    endfunction

    function void take_item(logic [ACT_W-1:0] act, logic [NODE_W-1:0] nd,
                            logic [ROW_W-1:0] bits);
      degree_answer_t   a;
      int               n;
      int               v;
      logic             entry;
      logic             leave;
      logic [DEG_W-1:0] d;
      a = '0;
      n = live_nodes();
      v = int'(nd);
      case (act)
        ACT_WRITE: begin
          rows[v] = bits | (ROW_W'(1) << v);
        end
        ACT_DEGREES: begin
          if (v < n) begin
            a.out_degree = row_out_degree(v, n);
            a.in_degree  = column_in_degree(v, n);
          end
        end
        ACT_MAX_OUT: begin
          a.out_degree = row_out_degree(0, n);
          for (int i = 1; i < n; i++) begin
            d = row_out_degree(i, n);
            if (d > a.out_degree) begin
              a.out_degree = d;
              a.best_node  = NODE_W'(i);
            end
          end
        end
        ACT_BOTHWAYS: begin
          if (v < n) begin
            a.both_ways = 1'b1;
            for (int i = 0; i < n; i++) begin
              if (i != v && !(rows[v][i] && rows[i][v])) a.both_ways = 1'b0;
            end
          end
        end
        ACT_ARRIVALS: begin
          if (v < n) begin
            for (int i = 0; i < n; i++) a.arrive_mask[i] = rows[i][v];
          end
        end
        ACT_CLASSIFY: begin
          for (int i = 0; i < n; i++) begin
            entry = 1'b0;
            leave = 1'b0;
            for (int j = 0; j < n; j++) begin
              if (j != i) begin
                entry = entry | rows[j][i];
                leave = leave | rows[i][j];
              end
            end
            if (!entry && !leave) a.isolated_mask[i] = 1'b1;
            else if (!entry) a.only_out_mask[i] = 1'b1;
            else if (!leave) a.only_in_mask[i] = 1'b1;
          end
        end
        default: begin
        end
      endcase
      answers_due.insert(answers_due.size(), a);
    endfunction

    task report(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
                 what, got, want, checked);
    endtask

    task check_answer(degree_answer_t got);
      degree_answer_t want;
      if (answers_due.size() == 0) begin
        report("result with nothing pending", '0, '0);
        return;
      end
      want = answers_due.pop_front();
      checked++;
      if (got.out_degree !== want.out_degree)
        report("out_degree", ROW_W'(got.out_degree), ROW_W'(want.out_degree));
      if (got.in_degree !== want.in_degree)
        report("in_degree", ROW_W'(got.in_degree), ROW_W'(want.in_degree));
      if (got.best_node !== want.best_node)
        report("best_node", ROW_W'(got.best_node), ROW_W'(want.best_node));
      if (got.both_ways !== want.both_ways)
        report("both_ways", ROW_W'(got.both_ways), ROW_W'(want.both_ways));
      if (got.arrive_mask !== want.arrive_mask)
        report("arrive_mask", got.arrive_mask, want.arrive_mask);
      if (got.isolated_mask !== want.isolated_mask)
        report("isolated_mask", got.isolated_mask, want.isolated_mask);
      if (got.only_in_mask !== want.only_in_mask)
        report("only_in_mask", got.only_in_mask, want.only_in_mask);
      if (got.only_out_mask !== want.only_out_mask)
        report("only_out_mask", got.only_out_mask, want.only_out_mask);
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [NC_W-1:0] cfg_data;

  amdq_in_if  in_bus ();
  amdq_out_if out_bus ();

  adjacency_matrix_degree_query dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  adjacency_shadow shadow = new();
  int              items_sent;
  int              cycles;
  bit              in_burst;
  bit              out_burst;

  // extremes first, then a spread of sizes
  logic [NC_W-1:0] node_count_plan [10] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16,
                                            5'd5, 5'd9, 5'd17, 5'd3, 5'd16};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[adjacency_matrix_degree_query] ERROR");
    $finish;
  end

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return ROW_W'($urandom & $urandom & $urandom);
      3, 4: return ROW_W'($urandom | $urandom | $urandom);
      5: return ROW_W'(1) << $urandom_range(0, 15);
      default: return ROW_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [ACT_W-1:0] act, logic [NODE_W-1:0] nd,
                           logic [ROW_W-1:0] bits);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.action   <= act;
    in_bus.node     <= nd;
    in_bus.row_bits <= bits;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    shadow.take_item(act, nd, bits);
    items_sent++;
  endtask

  task automatic random_item(int n);
    int                pick;
    logic [ACT_W-1:0]  act;
    logic [NODE_W-1:0] nd;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 6) == 0) nd = NODE_W'($urandom_range(0, 15));
    else nd = NODE_W'($urandom_range(0, n - 1));
    if (pick < 35) act = ACT_WRITE;
    else if (pick < 48) act = ACT_DEGREES;
    else if (pick < 58) act = ACT_MAX_OUT;
    else if (pick < 70) act = ACT_BOTHWAYS;
    else if (pick < 82) act = ACT_ARRIVALS;
    else if (pick < 96) act = ACT_CLASSIFY;
    else act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
    send_item(act, nd, random_row());
  endtask

  task automatic wait_idle();
    while (shadow.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [NC_W-1:0] setting);
    int n;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= setting;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.node_count = setting;
    n = shadow.live_nodes();
    // fill every live row before the mixed traffic
    for (int i = 0; i < n; i++) send_item(ACT_WRITE, NODE_W'(i), random_row());
    repeat (ITEMS_PER_PHASE) random_item(n);
    in_bus.valid <= 1'b0;
  endtask

  task automatic directed_items();
    // queries on the empty matrix, diagonal still clear
    send_item(ACT_DEGREES, 4'd0, '0);
    send_item(ACT_MAX_OUT, 4'd0, '0);
    send_item(ACT_CLASSIFY, 4'd0, '0);
    send_item(ACT_BOTHWAYS, 4'd3, '0);
    send_item(ACT_ARRIVALS, 4'd15, '1);
    send_item(ACT_WRITE, 4'd0, '1);
    send_item(ACT_WRITE, 4'd15, '0);
    send_item(ACT_WRITE, 4'd7, 16'hAAAA);
    send_item(ACT_WRITE, 4'd8, 16'h5555);
    send_item(ACT_DEGREES, 4'd0, '0);
    send_item(ACT_DEGREES, 4'd15, '1);
    send_item(ACT_MAX_OUT, 4'd15, '0);
    send_item(ACT_BOTHWAYS, 4'd0, '0);
    send_item(ACT_BOTHWAYS, 4'd15, '0);
    send_item(ACT_ARRIVALS, 4'd0, '0);
    send_item(ACT_ARRIVALS, 4'd15, '0);
    send_item(ACT_CLASSIFY, 4'd15, '1);
    send_item(ACT_SPARE_6, 4'd15, '1);
    send_item(ACT_SPARE_7, 4'd0, '1);
    send_item(ACT_DEGREES, 4'd15, '0);
    send_item(ACT_WRITE, 4'd1, '1);
    send_item(ACT_BOTHWAYS, 4'd0, '0);
    send_item(ACT_MAX_OUT, 4'd0, '0);
  endtask

  initial begin : result_sink
    int             gap;
    degree_answer_t got;
    out_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.out_degree    = out_bus.out_degree;
      got.in_degree     = out_bus.in_degree;
      got.best_node     = out_bus.best_node;
      got.both_ways     = out_bus.both_ways;
      got.arrive_mask   = out_bus.arrive_mask;
      got.isolated_mask = out_bus.isolated_mask;
      got.only_in_mask  = out_bus.only_in_mask;
      got.only_out_mask = out_bus.only_out_mask;
      shadow.check_answer(got);
    end
  end

  initial begin : stimulus
    shadow.clear();
    items_sent = 0;
    in_burst   = 1'b0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.action   <= '0;
    in_bus.node     <= '0;
    in_bus.row_bits <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    in_bus.valid <= 1'b0;
    foreach (node_count_plan[k]) run_phase(node_count_plan[k]);
    wait_idle();
    $display("covered %0d items and %0d checked results over %0d node_count settings",
             items_sent, shadow.checked, $size(node_count_plan) + 1);
    $display("mismatches counted: %0d", shadow.errors);
    if (shadow.errors == 0) begin
      $display("[adjacency_matrix_degree_query] OK");
    end else begin
      $display("[adjacency_matrix_degree_query] ERROR");
    end
    $finish;
  end

endmodule
